>>> rtl/tccs_pkg.sv
// ----------------------------------------------------------------------------
// tccs_pkg: shared definitions for the text console cursor and scroll engine
// Geometry constants, operation codes, and the item and result structures.
// ----------------------------------------------------------------------------
package tccs_pkg;

  localparam int LineWidth    = 80;
  localparam int ScreenLines  = 25;
  localparam int ConsoleCount = 4;
  localparam int VideoWords   = 16384;

  localparam int ConShare   = VideoWords / ConsoleCount;
  localparam int LimitLines = ConShare / LineWidth;
  localparam int MaxStart   = LimitLines - ScreenLines;

  localparam int AddrW   = 14;
  localparam int ModeW   = 2;
  localparam int ConW    = 2;
  localparam int CharW   = 8;
  localparam int AttrW   = 8;
  localparam int ConSelW = (ConsoleCount > 1) ? $clog2(ConsoleCount) : 1;
  localparam int LineW   = $clog2(LimitLines);
  localparam int ColW    = $clog2(LineWidth);

  localparam int QueueDepth = 2;
  localparam int QPtrW      = $clog2(QueueDepth);
  localparam int QCntW      = $clog2(QueueDepth + 1);

  typedef logic [AddrW-1:0]   addr_t;
  typedef logic [ModeW-1:0]   mode_t;
  typedef logic [ConW-1:0]    con_t;
  typedef logic [ConSelW-1:0] con_sel_t;
  typedef logic [CharW-1:0]   char_t;
  typedef logic [AttrW-1:0]   attr_t;
  typedef logic [LineW-1:0]   line_t;
  typedef logic [ColW-1:0]    col_t;

  localparam mode_t ModePut        = mode_t'(0);
  localparam mode_t ModeScrollUp   = mode_t'(1);
  localparam mode_t ModeScrollDown = mode_t'(2);
  localparam mode_t ModeSelect     = mode_t'(3);

  localparam char_t CharNewline   = char_t'(10);
  localparam char_t CharBackspace = char_t'(8);
  localparam char_t CharSpace     = char_t'(32);

  localparam attr_t AttrReset = attr_t'(7);

  typedef enum logic [2:0] {
    OpPutChar,
    OpNewline,
    OpBackspace,
    OpScrollUp,
    OpScrollDown,
    OpSelect,
    OpNop
  } op_kind_e;

  typedef struct packed {
    op_kind_e kind;
    con_t     console;
    char_t    char_code;
  } op_t;

  typedef struct packed {
    logic  write_valid;
    addr_t write_addr;
    char_t write_char;
    attr_t write_attr;
    logic  display_valid;
    addr_t cursor_pos;
    addr_t start_addr;
  } res_t;

  // Word address of a cell given as console, line and column.
  function automatic addr_t pos_addr(con_sel_t c, line_t line, col_t col);
    return AddrW'(32'(c) * ConShare + 32'(line) * LineWidth + 32'(col));
  endfunction

endpackage

>>> rtl/tccs_front.sv
// ----------------------------------------------------------------------------
// tccs_front: input stage
// Accepts input transactions and classifies them into console operations.
// ----------------------------------------------------------------------------
module tccs_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  tccs_pkg::mode_t mode_i,
  input  tccs_pkg::con_t  console_i,
  input  tccs_pkg::char_t char_code_i,
  output logic           op_valid_o,
  input  logic           op_ready_i,
  output tccs_pkg::op_t  op_o
);
  import tccs_pkg::*;

  logic     vld_q, vld_d;
  op_t      op_q, op_d;
  op_kind_e kind;

  always_comb begin
    if (32'(console_i) >= ConsoleCount) begin
      kind = OpNop;
    end else begin
      unique case (mode_i)
        ModePut: begin
          if (char_code_i == CharNewline) begin
            kind = OpNewline;
          end else if (char_code_i == CharBackspace) begin
            kind = OpBackspace;
          end else begin
            kind = OpPutChar;
          end
        end
        ModeScrollUp:   kind = OpScrollUp;
        ModeScrollDown: kind = OpScrollDown;
        ModeSelect:     kind = OpSelect;
        default:        kind = OpNop;
      endcase
    end
  end

  assign in_ready_o = !vld_q || op_ready_i;

  always_comb begin
    vld_d = vld_q;
    op_d  = op_q;
    if (in_ready_o) begin
      vld_d = in_valid_i;
      if (in_valid_i) begin
        op_d.kind      = kind;
        op_d.console   = console_i;
        op_d.char_code = char_code_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d;
  end

  assign op_valid_o = vld_q;
  assign op_o       = op_q;

endmodule

>>> rtl/tccs_fifo.sv
// ----------------------------------------------------------------------------
// tccs_fifo: operation queue
// Short queue that decouples classification from execution.
// ----------------------------------------------------------------------------
module tccs_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  tccs_pkg::op_t push_op_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output tccs_pkg::op_t pop_op_o
);
  import tccs_pkg::*;

  op_t              mem_q [QueueDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] cnt_q, cnt_d;
  logic             push, pop;

  assign push_ready_o = (32'(cnt_q) != QueueDepth);
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_op_o     = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (32'(wr_ptr_q) == QueueDepth - 1) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (32'(rd_ptr_q) == QueueDepth - 1) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_op_i;
    end
  end

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cnt_q) <= QueueDepth)
    else $error("queue count exceeds depth");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) || (32'(cnt_q) == QueueDepth) |-> wr_ptr_q == rd_ptr_q)
    else $error("queue pointers disagree with count");

  a_push_pop_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !pop |=> cnt_q == $past(cnt_q) + 1'b1)
    else $error("queue count did not follow a push");
`endif

endmodule

>>> rtl/tccs_back.sv
// ----------------------------------------------------------------------------
// tccs_back: execution stage
// Holds per-console cursor and view state, executes one operation per cycle
// while the output is not stalled and keeps the result in an output register.
// ----------------------------------------------------------------------------
module tccs_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            head_valid_i,
  output logic            head_ready_o,
  input  tccs_pkg::op_t   head_i,
  input  tccs_pkg::attr_t char_attr_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output tccs_pkg::res_t  res_o
);
  import tccs_pkg::*;

  // Cursor and view start are kept relative to the console base.
  line_t    line_q  [ConsoleCount];
  line_t    line_d  [ConsoleCount];
  col_t     col_q   [ConsoleCount];
  col_t     col_d   [ConsoleCount];
  line_t    start_q [ConsoleCount];
  line_t    start_d [ConsoleCount];
  con_sel_t active_q, active_d;
  logic     out_vld_q, out_vld_d;
  res_t     res_q, res_d;

  logic     fire;
  con_sel_t c;
  line_t    cl, nl, s, ns;
  col_t     cc, nc;
  int       tgt;

  assign c            = head_i.console[ConSelW-1:0];
  assign head_ready_o = !out_vld_q || out_ready_i;
  assign fire         = head_valid_i && head_ready_o;
  assign cl           = line_q[c];
  assign cc           = col_q[c];
  assign s            = start_q[c];

  always_comb begin
    nl       = cl;
    nc       = cc;
    ns       = s;
    active_d = active_q;
    res_d    = '0;
    tgt      = 0;
    unique case (head_i.kind)
      OpNewline: begin
        if (32'(cl) < LimitLines - 1) begin
          nl = cl + 1'b1;
          nc = '0;
        end
      end
      OpBackspace: begin
        if (cl != '0 || cc != '0) begin
          if (cc != '0) begin
            nc = cc - 1'b1;
          end else begin
            nl = cl - 1'b1;
            nc = ColW'(LineWidth - 1);
          end
          res_d.write_valid = 1'b1;
          res_d.write_addr  = pos_addr(c, nl, nc);
          res_d.write_char  = CharSpace;
          res_d.write_attr  = char_attr_i;
        end
      end
      OpPutChar: begin
        if (!(32'(cl) == LimitLines - 1 && 32'(cc) == LineWidth - 1)) begin
          res_d.write_valid = 1'b1;
          res_d.write_addr  = pos_addr(c, cl, cc);
          res_d.write_char  = head_i.char_code;
          res_d.write_attr  = char_attr_i;
          if (32'(cc) == LineWidth - 1) begin
            nl = cl + 1'b1;
            nc = '0;
          end else begin
            nc = cc + 1'b1;
          end
        end
      end
      OpScrollUp: begin
        if (s != '0) begin
          ns = s - 1'b1;
        end
      end
      OpScrollDown: begin
        if (32'(s) < MaxStart) begin
          ns = s + 1'b1;
        end
      end
      OpSelect: active_d = c;
      OpNop: ;
      default: ;
    endcase

    // The view follows the cursor down after a put, as far as the area allows.
    if (head_i.kind == OpPutChar || head_i.kind == OpNewline ||
        head_i.kind == OpBackspace) begin
      if (32'(nl) >= 32'(s) + ScreenLines) begin
        tgt = int'(nl) - ScreenLines + 1;
        ns  = (tgt > MaxStart) ? LineW'(MaxStart) : LineW'(tgt);
      end
    end

    if (head_i.kind != OpNop && c == active_d) begin
      res_d.display_valid = 1'b1;
      res_d.cursor_pos    = pos_addr(c, nl, nc);
      res_d.start_addr    = pos_addr(c, ns, '0);
    end
  end

  always_comb begin
    line_d  = line_q;
    col_d   = col_q;
    start_d = start_q;
    if (fire) begin
      line_d[c]  = nl;
      col_d[c]   = nc;
      start_d[c] = ns;
    end
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (head_ready_o) begin
      out_vld_d = head_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ConsoleCount; i++) begin
        line_q[i]  <= '0;
        col_q[i]   <= '0;
        start_q[i] <= '0;
      end
      active_q  <= '0;
      out_vld_q <= 1'b0;
    end else begin
      line_q    <= line_d;
      col_q     <= col_d;
      start_q   <= start_d;
      out_vld_q <= out_vld_d;
      if (fire) begin
        active_q <= active_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign res_o       = res_q;

`ifndef SYNTH
  a_start_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_valid_i |-> 32'(start_q[c]) <= MaxStart)
    else $error("view start beyond the usable area");

  a_cursor_visible: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && (head_i.kind == OpPutChar || head_i.kind == OpNewline ||
             head_i.kind == OpBackspace)
    |-> (32'(nl) < 32'(ns) + ScreenLines) || (32'(ns) == MaxStart))
    else $error("cursor left below the view after a put");

  a_select: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && head_i.kind == OpSelect |=> active_q == $past(c))
    else $error("select did not change the active console");
`endif

endmodule

>>> rtl/text_console_cursor_scroll.sv
// ----------------------------------------------------------------------------
// text_console_cursor_scroll: multi-console text cursor and scroll engine
// Results pass the input-stage register, the queue and the output register.
// Throughput is one transaction per cycle when the output is not stalled;
// the per-console state update is a read-modify-write in the execution stage.
// Reset clears all cursors and view starts to their console base, selects
// console zero and sets the attribute to 7; no clearing pass is needed.
// ----------------------------------------------------------------------------
module text_console_cursor_scroll (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  tccs_pkg::attr_t  cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  tccs_pkg::mode_t  mode_i,
  input  tccs_pkg::con_t   console_i,
  input  tccs_pkg::char_t  char_code_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic             write_valid_o,
  output tccs_pkg::addr_t  write_addr_o,
  output tccs_pkg::char_t  write_char_o,
  output tccs_pkg::attr_t  write_attr_o,
  output logic             display_valid_o,
  output tccs_pkg::addr_t  cursor_pos_o,
  output tccs_pkg::addr_t  start_addr_o
);
  import tccs_pkg::*;

  attr_t char_attr_q;
  logic  f_valid, f_ready, h_valid, h_ready;
  op_t   f_op, h_op;
  res_t  res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      char_attr_q <= AttrReset;
    end else if (cfg_we_i) begin
      char_attr_q <= cfg_wdata_i;
    end
  end

  tccs_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .mode_i      (mode_i),
    .console_i   (console_i),
    .char_code_i (char_code_i),
    .op_valid_o  (f_valid),
    .op_ready_i  (f_ready),
    .op_o        (f_op)
  );

  tccs_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_op_i    (f_op),
    .pop_valid_o  (h_valid),
    .pop_ready_i  (h_ready),
    .pop_op_o     (h_op)
  );

  tccs_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (h_valid),
    .head_ready_o (h_ready),
    .head_i       (h_op),
    .char_attr_i  (char_attr_q),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .res_o        (res)
  );

  assign write_valid_o   = res.write_valid;
  assign write_addr_o    = res.write_addr;
  assign write_char_o    = res.write_char;
  assign write_attr_o    = res.write_attr;
  assign display_valid_o = res.display_valid;
  assign cursor_pos_o    = res.cursor_pos;
  assign start_addr_o    = res.start_addr;

endmodule

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for the text console cursor and scroll engine
// Drives put-character, scroll and select transactions with bursty valid and
// a stalling receiver, predicts every console's cursor and view start, and
// checks each result field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tccs_pkg::*;

  logic  clk_i     = 1'b0;
  logic  rst_ni    = 1'b0;
  logic  cfg_we    = 1'b0;
  attr_t cfg_wdata = '0;
  logic  in_valid  = 1'b0;
  logic  in_ready;
  mode_t mode_q    = ModePut;
  con_t  con_q     = '0;
  char_t char_q    = '0;
  logic  out_valid;
  logic  out_ready = 1'b1;
  logic  wr_valid;
  addr_t wr_addr;
  char_t wr_char;
  attr_t wr_attr;
  logic  disp_valid;
  addr_t cursor_pos;
  addr_t start_addr;

  text_console_cursor_scroll DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .mode_i         (mode_q),
    .console_i      (con_q),
    .char_code_i    (char_q),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .write_valid_o  (wr_valid),
    .write_addr_o   (wr_addr),
    .write_char_o   (wr_char),
    .write_attr_o   (wr_attr),
    .display_valid_o(disp_valid),
    .cursor_pos_o   (cursor_pos),
    .start_addr_o   (start_addr)
  );

  always #4 clk_i = ~clk_i;

  // Shadow copy of the per-console cursor and view state.
  int unsigned cursor_tab [ConsoleCount];
  int unsigned view_tab   [ConsoleCount];
  int unsigned shown_con;
  attr_t       cell_attr;

  res_t expected_updates[$];
  res_t oldest;
  int   errors     = 0;
  int   burst_left = 0;
  int   stall_mode = 0;
  int   stall_left = 0;

  function automatic res_t apply_console_op(mode_t m, con_t c, char_t ch);
    res_t        r;
    int unsigned base;
    int unsigned lim;
    int unsigned cur;
    int unsigned guard;
    r = '0;
    if (int'(c) >= ConsoleCount) return r;
    base = int'(c) * ConShare;
    lim  = base + LimitLines * LineWidth;
    if (m == ModePut) begin
      cur = cursor_tab[c];
      if (ch == CharNewline) begin
        if (cur < lim - LineWidth) cur = base + LineWidth * ((cur - base) / LineWidth + 1);
      end else if (ch == CharBackspace) begin
        if (cur > base) begin
          cur--;
          r.write_valid = 1'b1;
          r.write_addr  = addr_t'(cur);
          r.write_char  = CharSpace;
          r.write_attr  = cell_attr;
        end
      end else if (cur < lim - 1) begin
        r.write_valid = 1'b1;
        r.write_addr  = addr_t'(cur);
        r.write_char  = ch;
        r.write_attr  = cell_attr;
        cur++;
      end
      cursor_tab[c] = cur;
      guard = 0;
      while (cur >= view_tab[c] + LineWidth * ScreenLines && guard < VideoWords) begin
        if (view_tab[c] + LineWidth * ScreenLines < lim) view_tab[c] += LineWidth;
        else break;
        guard++;
      end
    end else if (m == ModeScrollUp) begin
      if (view_tab[c] > base) view_tab[c] -= LineWidth;
    end else if (m == ModeScrollDown) begin
      if (view_tab[c] + LineWidth * ScreenLines < lim) view_tab[c] += LineWidth;
    end else begin
      shown_con = c;
    end
    if (c == shown_con) begin
      r.display_valid = 1'b1;
      r.cursor_pos    = addr_t'(cursor_tab[c]);
      r.start_addr    = addr_t'(view_tab[c]);
    end
    return r;
  endfunction

  function automatic char_t random_glyph();
    char_t ch;
    do ch = char_t'($urandom); while (ch == CharNewline || ch == CharBackspace);
    return ch;
  endfunction

  task automatic send_item(mode_t m, con_t c, char_t ch);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 8);
      in_valid <= 1'b0;
      mode_q   <= mode_t'($urandom);
      con_q    <= con_t'($urandom);
      char_q   <= char_t'($urandom);
      repeat (gap) @(posedge clk_i);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
    end
    in_valid <= 1'b1;
    mode_q   <= m;
    con_q    <= c;
    char_q   <= ch;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    expected_updates.push_back(apply_console_op(m, c, ch));
    burst_left--;
  endtask

  task automatic set_char_attr(attr_t v);
    in_valid <= 1'b0;
    while (expected_updates.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    cell_attr  = v;
    burst_left = 0;
  endtask

  task automatic test_directed_edges();
    send_item(ModePut, 2'd0, 8'h41);
    send_item(ModePut, 2'd0, 8'h00);
    send_item(ModePut, 2'd0, 8'hFF);
    send_item(ModePut, 2'd0, CharNewline);
    send_item(ModePut, 2'd0, CharBackspace);
    send_item(ModePut, 2'd1, CharBackspace);
    send_item(ModeScrollUp, 2'd0, 8'h00);
    send_item(ModeScrollDown, 2'd0, 8'h55);
    send_item(ModeScrollUp, 2'd0, CharNewline);
    send_item(ModeScrollDown, 2'd1, 8'hFF);
    send_item(ModeSelect, 2'd3, 8'hAA);
    send_item(ModePut, 2'd3, 8'h7F);
    send_item(ModePut, 2'd3, CharNewline);
    send_item(ModeSelect, 2'd1, 8'h00);
    send_item(ModePut, 2'd1, CharSpace);
    send_item(ModeSelect, 2'd0, 8'hFF);
    send_item(ModePut, 2'd2, 8'h5A);
    send_item(ModePut, 2'd2, CharNewline);
    send_item(ModePut, 2'd2, CharBackspace);
    send_item(ModeScrollDown, 2'd3, CharBackspace);
    send_item(ModePut, 2'd0, 8'h80);
  endtask

  task automatic test_random_mix(int count);
    con_t  focus;
    mode_t m;
    con_t  c;
    char_t ch;
    int    pick;
    focus = con_t'($urandom);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 15) == 0) focus = con_t'($urandom);
      c    = ($urandom_range(0, 3) == 0) ? con_t'($urandom) : focus;
      ch   = char_t'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        m = ModePut;
        if (pick < 18) ch = CharNewline;
        else if (pick < 28) ch = CharBackspace;
      end else if (pick < 80) m = ModeScrollUp;
      else if (pick < 90) m = ModeScrollDown;
      else m = ModeSelect;
      send_item(m, c, ch);
    end
  endtask

  task automatic test_console_fill(con_t c);
    for (int i = 0; i < LimitLines + 1; i++) begin
      send_item(ModePut, c, CharNewline);
      if ($urandom_range(0, 2) == 0) send_item(ModePut, c, random_glyph());
    end
    for (int i = 0; i < LineWidth + 4; i++) send_item(ModePut, c, random_glyph());
    repeat (3) send_item(ModeScrollDown, c, char_t'($urandom));
    repeat (30) send_item(ModeScrollUp, c, char_t'($urandom));
    repeat (3) send_item(ModePut, c, CharBackspace);
  endtask

  task automatic test_attr_extremes();
    set_char_attr(8'h00);
    test_random_mix(60);
    set_char_attr(8'hFF);
    test_random_mix(60);
  endtask

  task automatic test_fill_active_and_hidden();
    set_char_attr(attr_t'($urandom));
    send_item(ModeSelect, 2'd2, char_t'($urandom));
    test_console_fill(2'd2);
    test_console_fill(2'd1);
  endtask

  task automatic test_random_traffic();
    for (int p = 0; p < 3; p++) begin
      set_char_attr(attr_t'($urandom));
      test_random_mix(60);
    end
    set_char_attr(AttrReset);
    test_random_mix(60);
  endtask

  task automatic check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid && out_ready) begin
      if (expected_updates.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual addr %0h cursor %0h",
                 $time, wr_addr, cursor_pos);
      end else begin
        oldest = expected_updates.pop_front();
        check_field("write_valid", oldest.write_valid, wr_valid);
        check_field("write_addr", oldest.write_addr, wr_addr);
        check_field("write_char", oldest.write_char, wr_char);
        check_field("write_attr", oldest.write_attr, wr_attr);
        check_field("display_valid", oldest.display_valid, disp_valid);
        check_field("cursor_pos", oldest.cursor_pos, cursor_pos);
        check_field("start_addr", oldest.start_addr, start_addr);
      end
    end
  end

  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(16, 200);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      2: out_ready <= ($urandom_range(0, 3) == 0);
      default: out_ready <= ($urandom_range(0, 7) != 0);
    endcase
  end

  initial begin
    for (int i = 0; i < ConsoleCount; i++) begin
      cursor_tab[i] = i * ConShare;
      view_tab[i]   = i * ConShare;
    end
    shown_con = 0;
    cell_attr = AttrReset;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_edges();
    test_attr_extremes();
    test_fill_active_and_hidden();
    test_random_traffic();
    in_valid <= 1'b0;
    while (expected_updates.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule
